// ===== design/classifier_product_fusion_binary_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for classifier_product_fusion_binary
// Implication helpers sampled on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef CLASSIFIER_PRODUCT_FUSION_BINARY_MACROS_SVH
`define CLASSIFIER_PRODUCT_FUSION_BINARY_MACROS_SVH

// same-cycle implication
`define CPFB_ASSERT_IMP(label, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error(msg);

// next-cycle implication
`define CPFB_ASSERT_NEXT(label, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error(msg);

`endif

// ===== design/cpfb_pkg.sv =====
// ---------------------------------------------------------------------------
// cpfb_pkg
// Shared widths, constants and the job record passed from front to back.
// ---------------------------------------------------------------------------
package cpfb_pkg;

    localparam int SCORE_W = 16;
    localparam int SUM_W   = 22;
    localparam int CNT_W   = 7;
    localparam int Q_W     = 10;
    localparam int PROD_W  = 20;
    localparam int ACC_W   = 27;
    localparam int TOT_W   = 28;
    localparam int NUM_W   = 39;
    localparam int MASK_W  = 32;

    localparam int SCALE      = 1000;
    localparam int SCALE_TWO  = 2000;

    typedef enum logic [0:0] {
        REG_CROP_MASK   = 1'b0,
        REG_NOCROP_MASK = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [SUM_W-1:0] sum_first;
        logic [SUM_W-1:0] sum_second;
        logic             overflow;
    } job_t;

endpackage

// ===== design/classifier_product_fusion_binary.sv =====
// ---------------------------------------------------------------------------
// classifier_product_fusion_binary
// Product-rule fusion of two classifiers into a crop / no-crop decision.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-----------------------------------------
//   input    | start, busy         | score_first, score_second, last_class
//   result   | done (strobe)       | is_crop, confidence, error_flag
//   config   | wr_en               | wr_index, wr_data
//
// Beats are taken only while busy is low. After the final beat busy stays
// high through the pop, then while each class goes through the two 10-step
// serial dividers running side by side, then for the totals and the
// confidence divide. An error seen at the pop goes straight to the result.
// done strobes for one cycle, the first with busy low; it cannot be held off.
// Reset clears control state and masks; score stores are not cleared.
// ---------------------------------------------------------------------------
`include "classifier_product_fusion_binary_macros.svh"

module classifier_product_fusion_binary #(
    parameter int MAX_CLASSES = 32,
    parameter int SCORE_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] score_first,
    input  logic [15:0] score_second,
    input  logic        last_class,
    output logic        done,
    output logic        is_crop,
    output logic [9:0]  confidence,
    output logic        error_flag,
    input  logic        wr_en,
    input  logic [0:0]  wr_index,
    input  logic [31:0] wr_data
);

    logic [cpfb_pkg::MASK_W-1:0] crop_mask_reg;
    logic [cpfb_pkg::MASK_W-1:0] nocrop_mask_reg;
    logic                        accept;
    logic                        push, pop, q_valid, back_active;
    cpfb_pkg::job_t              job_in, job_out;
    logic [$clog2(MAX_CLASSES)-1:0] rd_addr;
    logic [cpfb_pkg::SCORE_W-1:0]   rd_first, rd_second;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crop_mask_reg   <= '0;
            nocrop_mask_reg <= '0;
        end
        else if (wr_en)
        begin
            case (cpfb_pkg::reg_index_t'(wr_index))
                cpfb_pkg::REG_CROP_MASK:   crop_mask_reg   <= wr_data;
                cpfb_pkg::REG_NOCROP_MASK: nocrop_mask_reg <= wr_data;
                default:                   crop_mask_reg   <= crop_mask_reg;
            endcase
        end
    end

    assign busy   = q_valid || back_active;
    assign accept = start && !busy;

    cpfb_front #(
        .MAX_CLASSES (MAX_CLASSES),
        .SCORE_BITS  (SCORE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .score_first  (score_first),
        .score_second (score_second),
        .last_class   (last_class),
        .push         (push),
        .job          (job_in),
        .rd_addr      (rd_addr),
        .rd_first     (rd_first),
        .rd_second    (rd_second)
    );

    cpfb_jobq u_jobq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .job_in  (job_in),
        .pop     (pop),
        .valid   (q_valid),
        .job_out (job_out)
    );

    cpfb_back #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (q_valid),
        .job         (job_out),
        .pop         (pop),
        .active      (back_active),
        .crop_mask   (crop_mask_reg),
        .nocrop_mask (nocrop_mask_reg),
        .rd_addr     (rd_addr),
        .rd_first    (rd_first),
        .rd_second   (rd_second),
        .done        (done),
        .is_crop     (is_crop),
        .confidence  (confidence),
        .error_flag  (error_flag)
    );

    `CPFB_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
    `CPFB_ASSERT_IMP(a_err_zero, done && error_flag, !is_crop && (confidence == 10'd0), "error result not zero")
    `CPFB_ASSERT_IMP(a_conf_range, done && !error_flag, (confidence >= 10'd500) && (confidence <= 10'd1000), "confidence out of range")
    `CPFB_ASSERT_NEXT(a_last_busy, accept && last_class, busy, "final beat did not raise busy")

endmodule

// ===== design/cpfb_div.sv =====
// ---------------------------------------------------------------------------
// cpfb_div
// Restoring divider, one quotient bit per cycle; quotient known below 2^Q_W.
// ---------------------------------------------------------------------------
module cpfb_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [cpfb_pkg::NUM_W-1:0] num,
    input  logic [cpfb_pkg::TOT_W-1:0] den,
    output logic                       done,
    output logic [cpfb_pkg::Q_W-1:0]   quo
);

    localparam int KW = $clog2(cpfb_pkg::Q_W);

    logic                       busy_reg;
    logic                       done_reg;
    logic [KW-1:0]              k_reg;
    logic [cpfb_pkg::NUM_W-1:0] rem_reg;
    logic [cpfb_pkg::TOT_W-1:0] den_reg;
    logic [cpfb_pkg::Q_W-1:0]   quo_reg;
    logic [cpfb_pkg::NUM_W-1:0] trial;

    assign trial = cpfb_pkg::NUM_W'(den_reg) << k_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                k_reg    <= KW'(cpfb_pkg::Q_W - 1);
            end
            else if (busy_reg)
            begin
                if (k_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    k_reg <= k_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            den_reg <= den;
            quo_reg <= '0;
        end
        else if (busy_reg && (rem_reg >= trial))
        begin
            rem_reg        <= rem_reg - trial;
            quo_reg[k_reg] <= 1'b1;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== design/cpfb_front.sv =====
// ---------------------------------------------------------------------------
// cpfb_front
// Takes score beats, stores them per class, keeps running sums and count.
// ---------------------------------------------------------------------------
module cpfb_front #(
    parameter int MAX_CLASSES = 32,
    parameter int SCORE_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic [cpfb_pkg::SCORE_W-1:0] score_first,
    input  logic [cpfb_pkg::SCORE_W-1:0] score_second,
    input  logic                         last_class,
    output logic                         push,
    output cpfb_pkg::job_t               job,
    input  logic [$clog2(MAX_CLASSES)-1:0] rd_addr,
    output logic [cpfb_pkg::SCORE_W-1:0] rd_first,
    output logic [cpfb_pkg::SCORE_W-1:0] rd_second
);

    localparam int IW = $clog2(MAX_CLASSES);
    localparam logic [cpfb_pkg::SCORE_W-1:0] SMASK = (SCORE_BITS >= cpfb_pkg::SCORE_W) ?
        {cpfb_pkg::SCORE_W{1'b1}} : cpfb_pkg::SCORE_W'((64'd1 << SCORE_BITS) - 64'd1);

    logic [cpfb_pkg::SCORE_W-1:0] first_mem  [MAX_CLASSES];
    logic [cpfb_pkg::SCORE_W-1:0] second_mem [MAX_CLASSES];
    logic [cpfb_pkg::SCORE_W-1:0] rd_first_reg;
    logic [cpfb_pkg::SCORE_W-1:0] rd_second_reg;

    logic [cpfb_pkg::SUM_W-1:0] sum_first_reg,  sum_first_next;
    logic [cpfb_pkg::SUM_W-1:0] sum_second_reg, sum_second_next;
    logic [cpfb_pkg::CNT_W-1:0] count_reg,      count_next;
    logic                       ovf_reg,        ovf_next;
    logic [cpfb_pkg::SCORE_W-1:0] s1, s2;
    logic                       room;

    assign s1   = score_first & SMASK;
    assign s2   = score_second & SMASK;
    assign room = count_reg < cpfb_pkg::CNT_W'(MAX_CLASSES);

    always_comb
    begin
        sum_first_next  = sum_first_reg;
        sum_second_next = sum_second_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        if (room)
        begin
            sum_first_next  = sum_first_reg + cpfb_pkg::SUM_W'(s1);
            sum_second_next = sum_second_reg + cpfb_pkg::SUM_W'(s2);
            count_next      = count_reg + 1'b1;
        end
        else
        begin
            ovf_next = 1'b1;
        end
    end

    assign push            = accept && last_class;
    assign job.count       = count_next;
    assign job.sum_first   = sum_first_next;
    assign job.sum_second  = sum_second_next;
    assign job.overflow    = ovf_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_first_reg  <= '0;
            sum_second_reg <= '0;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
        end
        else if (accept)
        begin
            if (last_class)
            begin
                sum_first_reg  <= '0;
                sum_second_reg <= '0;
                count_reg      <= '0;
                ovf_reg        <= 1'b0;
            end
            else
            begin
                sum_first_reg  <= sum_first_next;
                sum_second_reg <= sum_second_next;
                count_reg      <= count_next;
                ovf_reg        <= ovf_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && room)
        begin
            first_mem[count_reg[IW-1:0]]  <= s1;
            second_mem[count_reg[IW-1:0]] <= s2;
        end
        rd_first_reg  <= first_mem[rd_addr];
        rd_second_reg <= second_mem[rd_addr];
    end

    assign rd_first  = rd_first_reg;
    assign rd_second = rd_second_reg;

endmodule

// ===== design/cpfb_jobq.sv =====
// ---------------------------------------------------------------------------
// cpfb_jobq
// Single-entry job queue between front and back.
// ---------------------------------------------------------------------------
module cpfb_jobq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cpfb_pkg::job_t job_in,
    input  logic           pop,
    output logic           valid,
    output cpfb_pkg::job_t job_out
);

    logic           valid_reg;
    cpfb_pkg::job_t job_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push)
        begin
            valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            job_reg <= job_in;
        end
    end

    assign valid   = valid_reg;
    assign job_out = job_reg;

endmodule

// ===== design/cpfb_back.sv =====
// ---------------------------------------------------------------------------
// cpfb_back
// Walks the stored classes: scales, fuses, masks, then works out confidence.
// ---------------------------------------------------------------------------
module cpfb_back #(
    parameter int MAX_CLASSES = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           job_valid,
    input  cpfb_pkg::job_t                 job,
    output logic                           pop,
    output logic                           active,
    input  logic [cpfb_pkg::MASK_W-1:0]    crop_mask,
    input  logic [cpfb_pkg::MASK_W-1:0]    nocrop_mask,
    output logic [$clog2(MAX_CLASSES)-1:0] rd_addr,
    input  logic [cpfb_pkg::SCORE_W-1:0]   rd_first,
    input  logic [cpfb_pkg::SCORE_W-1:0]   rd_second,
    output logic                           done,
    output logic                           is_crop,
    output logic [cpfb_pkg::Q_W-1:0]       confidence,
    output logic                           error_flag
);

    localparam int IW = $clog2(MAX_CLASSES);

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_LOAD, S_DIV, S_MUL, S_ACC,
        S_FIN, S_NUM, S_CDIV, S_CWAIT, S_OUT
    } state_t;

    state_t                      state_reg;
    cpfb_pkg::job_t              job_reg;
    logic [IW-1:0]               idx_reg;
    logic [cpfb_pkg::Q_W-1:0]    a_reg, b_reg;
    logic [cpfb_pkg::PROD_W-1:0] prod_reg;
    logic [cpfb_pkg::Q_W:0]      sab_reg;
    logic [cpfb_pkg::ACC_W-1:0]  tp_reg, p0p_reg, p1p_reg, p0s_reg, p1s_reg;
    logic [cpfb_pkg::TOT_W-1:0]  tot_reg, win_reg;
    logic [cpfb_pkg::NUM_W-1:0]  num_reg;
    logic                        crop_reg, err_reg;
    logic [cpfb_pkg::Q_W-1:0]    conf_reg;
    logic                        done_reg, is_crop_reg, error_flag_reg;
    logic [cpfb_pkg::Q_W-1:0]    confidence_reg;

    logic                        div_start;
    logic [cpfb_pkg::NUM_W-1:0]  num_a, num_b;
    logic [cpfb_pkg::TOT_W-1:0]  den_a, den_b;
    logic                        done_a, done_b;
    logic [cpfb_pkg::Q_W-1:0]    quo_a, quo_b;
    logic                        in_crop, in_nocrop;
    logic [cpfb_pkg::ACC_W-1:0]  p0, p1;
    logic [cpfb_pkg::TOT_W-1:0]  tot;

    assign pop     = (state_reg == S_IDLE) && job_valid;
    assign active  = (state_reg != S_IDLE);
    assign rd_addr = idx_reg;

    assign div_start = (state_reg == S_LOAD) || (state_reg == S_CDIV);
    assign num_a = (state_reg == S_CDIV) ? num_reg :
                   cpfb_pkg::NUM_W'(rd_first) * cpfb_pkg::NUM_W'(cpfb_pkg::SCALE);
    assign den_a = (state_reg == S_CDIV) ? {tot_reg[cpfb_pkg::TOT_W-2:0], 1'b0} :
                   cpfb_pkg::TOT_W'(job_reg.sum_first);
    assign num_b = cpfb_pkg::NUM_W'(rd_second) * cpfb_pkg::NUM_W'(cpfb_pkg::SCALE);
    assign den_b = cpfb_pkg::TOT_W'(job_reg.sum_second);

    cpfb_div u_div_a (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_a),
        .den   (den_a),
        .done  (done_a),
        .quo   (quo_a)
    );

    cpfb_div u_div_b (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_b),
        .den   (den_b),
        .done  (done_b),
        .quo   (quo_b)
    );

    assign in_crop   = (32'(idx_reg) < cpfb_pkg::MASK_W) && crop_mask[5'(idx_reg)];
    assign in_nocrop = (32'(idx_reg) < cpfb_pkg::MASK_W) && nocrop_mask[5'(idx_reg)];

    assign p0  = (tp_reg == '0) ? p0s_reg : p0p_reg;
    assign p1  = (tp_reg == '0) ? p1s_reg : p1p_reg;
    assign tot = cpfb_pkg::TOT_W'(p0) + cpfb_pkg::TOT_W'(p1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            done_reg       <= 1'b0;
            is_crop_reg    <= 1'b0;
            confidence_reg <= '0;
            error_flag_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        job_reg <= job;
                        idx_reg <= '0;
                        tp_reg  <= '0;
                        p0p_reg <= '0;
                        p1p_reg <= '0;
                        p0s_reg <= '0;
                        p1s_reg <= '0;
                        if (job.overflow || (job.sum_first == '0) || (job.sum_second == '0))
                        begin
                            err_reg   <= 1'b1;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            err_reg   <= 1'b0;
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ:
                begin
                    state_reg <= S_LOAD;
                end
                S_LOAD:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (done_a && done_b)
                    begin
                        a_reg     <= quo_a;
                        b_reg     <= quo_b;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= cpfb_pkg::PROD_W'(a_reg) * cpfb_pkg::PROD_W'(b_reg);
                    sab_reg   <= {1'b0, a_reg} + {1'b0, b_reg};
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    tp_reg <= tp_reg + cpfb_pkg::ACC_W'(prod_reg);
                    if (in_nocrop)
                    begin
                        p0p_reg <= p0p_reg + cpfb_pkg::ACC_W'(prod_reg);
                        p0s_reg <= p0s_reg + cpfb_pkg::ACC_W'(sab_reg);
                    end
                    if (in_crop)
                    begin
                        p1p_reg <= p1p_reg + cpfb_pkg::ACC_W'(prod_reg);
                        p1s_reg <= p1s_reg + cpfb_pkg::ACC_W'(sab_reg);
                    end
                    if ((cpfb_pkg::CNT_W'(idx_reg) + 1'b1) == job_reg.count)
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_READ;
                    end
                end
                S_FIN:
                begin
                    crop_reg <= (p0 < p1);
                    win_reg  <= (p0 < p1) ? cpfb_pkg::TOT_W'(p1) : cpfb_pkg::TOT_W'(p0);
                    tot_reg  <= tot;
                    if (tot == '0)
                    begin
                        err_reg   <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_NUM;
                    end
                end
                S_NUM:
                begin
                    num_reg <= cpfb_pkg::NUM_W'(win_reg) * cpfb_pkg::NUM_W'(cpfb_pkg::SCALE_TWO)
                             + cpfb_pkg::NUM_W'(tot_reg);
                    state_reg <= S_CDIV;
                end
                S_CDIV:
                begin
                    state_reg <= S_CWAIT;
                end
                S_CWAIT:
                begin
                    if (done_a)
                    begin
                        conf_reg  <= quo_a;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    done_reg       <= 1'b1;
                    is_crop_reg    <= err_reg ? 1'b0 : crop_reg;
                    confidence_reg <= err_reg ? '0 : conf_reg;
                    error_flag_reg <= err_reg;
                    state_reg      <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done       = done_reg;
    assign is_crop    = is_crop_reg;
    assign confidence = confidence_reg;
    assign error_flag = error_flag_reg;

endmodule

// ===== sim/classifier_product_fusion_binary_tb.sv =====
// ---------------------------------------------------------------------------
// classifier_product_fusion_binary_tb
// Drives per-class score beats into the fusion block and checks each
// per-pixel decision against a local product-rule predictor. Covers
// extremes, error pixels, ties and overflow, then random pixels under
// several mask settings, with random gaps on the input side.
// ---------------------------------------------------------------------------
module classifier_product_fusion_binary_tb;

    localparam int N_CLS = 32;

    typedef struct {
        logic       crop;
        logic [9:0] conf;
        logic       err;
    } decision_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [15:0] score_first;
    logic [15:0] score_second;
    logic        last_class;
    logic        done;
    logic        is_crop;
    logic [9:0]  confidence;
    logic        error_flag;
    logic        wr_en;
    logic [0:0]  wr_index;
    logic [31:0] wr_data;

    logic [31:0] crop_mask_m;
    logic [31:0] nocrop_mask_m;
    logic [15:0] first_st [N_CLS];
    logic [15:0] second_st [N_CLS];
    longint      first_total;
    longint      second_total;
    int          cls_count;
    bit          ovf_seen;
    decision_t   decisions_q[$];
    bit          failed;

    classifier_product_fusion_binary u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .score_first(score_first), .score_second(score_second),
        .last_class(last_class), .done(done), .is_crop(is_crop),
        .confidence(confidence), .error_flag(error_flag),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic decision_t fuse_pixel();
        decision_t d;
        longint a [N_CLS];
        longint b [N_CLS];
        longint f [N_CLS];
        longint total;
        longint p0;
        longint p1;
        longint sum;
        longint win;
        d.crop = 1'b0;
        d.conf = '0;
        d.err  = 1'b1;
        total = 0;
        p0 = 0;
        p1 = 0;
        if (ovf_seen || first_total == 0 || second_total == 0)
            return d;
        for (int i = 0; i < cls_count; i++)
        begin
            a[i] = (cpfb_pkg::SCALE * longint'(first_st[i])) / first_total;
            b[i] = (cpfb_pkg::SCALE * longint'(second_st[i])) / second_total;
            f[i] = a[i] * b[i];
            total += f[i];
        end
        if (total == 0)
            for (int i = 0; i < cls_count; i++)
                f[i] = a[i] + b[i];
        for (int i = 0; i < cls_count; i++)
        begin
            if (nocrop_mask_m[i])
                p0 += f[i];
            if (crop_mask_m[i])
                p1 += f[i];
        end
        sum = p0 + p1;
        if (sum == 0)
            return d;
        d.err  = 1'b0;
        d.crop = p0 < p1;
        win    = (p0 < p1) ? p1 : p0;
        d.conf = 10'((cpfb_pkg::SCALE_TWO * win + sum) / (2 * sum));
        return d;
    endfunction

    function automatic void take_beat(logic [15:0] s1, logic [15:0] s2, logic lst);
        if (cls_count < N_CLS)
        begin
            first_st[cls_count]  = s1;
            second_st[cls_count] = s2;
            first_total  += s1;
            second_total += s2;
            cls_count++;
        end
        else
            ovf_seen = 1'b1;
        if (lst)
        begin
            decisions_q.insert(decisions_q.size(), fuse_pixel());
            first_total  = 0;
            second_total = 0;
            cls_count    = 0;
            ovf_seen     = 1'b0;
        end
    endfunction

    // entered and left at a falling edge
    task automatic send_beat(logic [15:0] s1, logic [15:0] s2, logic lst, int gap);
        start        <= 1'b1;
        score_first  <= s1;
        score_second <= s2;
        last_class   <= lst;
        do
            @(posedge clk);
        while (busy);
        take_beat(s1, s2, lst);
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (decisions_q.size() != 0 || busy)
            @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    task automatic write_masks(logic [31:0] crop_m, logic [31:0] nocrop_m);
        drain();
        wr_en    <= 1'b1;
        wr_index <= cpfb_pkg::REG_CROP_MASK;
        wr_data  <= crop_m;
        @(negedge clk);
        wr_index <= cpfb_pkg::REG_NOCROP_MASK;
        wr_data  <= nocrop_m;
        @(negedge clk);
        wr_en <= 1'b0;
        crop_mask_m   = crop_m;
        nocrop_mask_m = nocrop_m;
    endtask

    task automatic send_pixel(int n, int mode);
        logic [15:0] s1;
        logic [15:0] s2;
        for (int i = 0; i < n; i++)
        begin
            case (mode)
                0: begin s1 = 16'($urandom); s2 = 16'($urandom); end
                1: begin
                    s1 = 16'($urandom_range(0, 40));
                    s2 = 16'($urandom_range(0, 40));
                end
                2: begin
                    s1 = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom);
                    s2 = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom);
                end
                default: begin s1 = 16'hFFFF; s2 = 16'hFFFF; end
            endcase
            send_beat(s1, s2, i == n - 1, rand_gap());
        end
    endtask

    task automatic test_directed();
        write_masks(32'h0000_0002, 32'h0000_0001);
        send_beat(16'hFFFF, 16'hFFFF, 1'b0, 0);
        send_beat(16'h0000, 16'h0001, 1'b1, 0);
        send_beat(16'd0, 16'd0, 1'b0, 0);
        send_beat(16'd0, 16'd5, 1'b1, 2);
        send_beat(16'd1000, 16'd0, 1'b0, 0);
        send_beat(16'd0, 16'd1000, 1'b1, 0);
        send_beat(16'd7, 16'd9, 1'b0, 0);
        send_beat(16'd7, 16'd9, 1'b1, 0);
        send_beat(16'hFFFF, 16'h0001, 1'b1, 0);
        write_masks(32'h0000_0001, 32'h0000_0001);
        send_beat(16'd3, 16'd4, 1'b0, 0);
        send_beat(16'd5, 16'd6, 1'b1, 0);
        write_masks(32'd0, 32'd0);
        send_beat(16'd3, 16'd4, 1'b0, 0);
        send_beat(16'd5, 16'd6, 1'b1, 0);
    endtask

    task automatic test_class_limits();
        write_masks(32'hAAAA_AAAA, 32'h5555_5555);
        send_pixel(N_CLS, 3);
        send_pixel(N_CLS + 1, 0);
        send_pixel(N_CLS, 0);
    endtask

    task automatic test_random(int beats);
        int sent;
        int n;
        int r;
        sent = 0;
        while (sent < beats)
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
                n = N_CLS;
            else if (r < 8)
                n = $urandom_range(N_CLS + 1, N_CLS + 4);
            else
                n = $urandom_range(1, 6);
            send_pixel(n, $urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0);
            sent += n;
            if ($urandom_range(0, 29) == 0)
                drain();
        end
    endtask

    always @(posedge clk)
    begin
        decision_t d;
        if (rst_n && done)
        begin
            if (decisions_q.size() == 0)
            begin
                $error("result with no pending pixel");
                failed = 1'b1;
            end
            else
            begin
                d = decisions_q.pop_front();
                if (is_crop !== d.crop)
                begin
                    $error("is_crop exp %0d got %0d", d.crop, is_crop);
                    failed = 1'b1;
                end
                if (confidence !== d.conf)
                begin
                    $error("confidence exp %0d got %0d", d.conf, confidence);
                    failed = 1'b1;
                end
                if (error_flag !== d.err)
                begin
                    $error("error_flag exp %0d got %0d", d.err, error_flag);
                    failed = 1'b1;
                end
            end
        end
    end

    initial
    begin
        #8_000_000;
        $display("FAIL classifier_product_fusion_binary");
        $finish;
    end

    initial
    begin
        failed        = 1'b0;
        crop_mask_m   = '0;
        nocrop_mask_m = '0;
        first_total   = 0;
        second_total  = 0;
        cls_count     = 0;
        ovf_seen      = 1'b0;
        rst_n         = 1'b0;
        start         = 1'b0;
        score_first   = '0;
        score_second  = '0;
        last_class    = 1'b0;
        wr_en         = 1'b0;
        wr_index      = cpfb_pkg::REG_CROP_MASK;
        wr_data       = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_class_limits();
        write_masks(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        test_random(100);
        write_masks($urandom, $urandom);
        test_random(200);
        write_masks(32'hFFFF_FFFF, 32'd0);
        test_random(60);
        write_masks($urandom, $urandom);
        test_random(200);
        drain();
        if (!failed)
            $display("PASS classifier_product_fusion_binary");
        else
            $display("FAIL classifier_product_fusion_binary");
        $finish;
    end

endmodule
